>>> design/pds_pkg.sv
// Package: types, constants and state codes for pair_distance_by_separation.
package pds_pkg;

    localparam int MAX_BEADS = 64;
    localparam int IDX_W     = $clog2(MAX_BEADS);
    localparam int CNT_W     = $clog2(MAX_BEADS + 1);
    localparam int POS_W     = 24;
    localparam int TIME_W    = 31;
    localparam int SUM_W     = 64;
    localparam int COUNT_W   = 40;
    localparam int SQ_W      = 50;
    localparam int ADDR_W    = 4;

    localparam logic [ADDR_W-1:0] ADDR_BEADS = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_WSTART = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_WEND = 4'h8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        bead_index;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [30:0]       frame_time;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  separation;
        logic [63:0] mean_sq_distance;
        logic        no_data;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAIR_RD,
        ST_PAIR_SQ,
        ST_PAIR_SUM,
        ST_PAIR_WR,
        ST_FIN_RD,
        ST_FIN_DIV,
        ST_FIN_OUT
    } state_t;

endpackage

>>> design/pair_distance_by_separation.sv
// Top level: bead stores, pair accumulation sequencer and mean output.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------
//  input    | in_valid / in_ready    | in_item  (in_item_t)
//  output   | out_valid / out_ready  | out_item (out_item_t)
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// A frame_end load in the window walks n*(n+1)/2 pairs; each pair passes the
// read, square, sum and write states, the read-modify-write of the sum and
// count memory. A finish gives one result per separation from 0 to n-2, each
// from the bit-serial 64-bit divider. After reset a clearing pass zeroes the
// sum and count memories; no item is taken during it. A stalled output holds
// the sequencer.
module pair_distance_by_separation
    import pds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration registers
    logic [6:0]        beads_reg;
    logic [TIME_W-1:0] wstart_reg;
    logic [TIME_W-1:0] wend_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beads_reg  <= 7'd64;
            wstart_reg <= '0;
            wend_reg   <= {TIME_W{1'b1}};
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_BEADS:  beads_reg  <= pwdata[6:0];
                ADDR_WSTART: wstart_reg <= pwdata[TIME_W-1:0];
                ADDR_WEND:   wend_reg   <= pwdata[TIME_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_BEADS:  prdata = {25'd0, beads_reg};
            ADDR_WSTART: prdata = {1'b0, wstart_reg};
            ADDR_WEND:   prdata = {1'b0, wend_reg};
            default:     prdata = '0;
        endcase
    end

    // clamp the bead count
    logic [CNT_W-1:0] n_beads;
    always_comb
    begin
        if (beads_reg < 7'd2)
            n_beads = CNT_W'(2);
        else if (beads_reg > 7'(MAX_BEADS))
            n_beads = CNT_W'(MAX_BEADS);
        else
            n_beads = CNT_W'(beads_reg);
    end

    // memories
    logic [3*POS_W-1:0]   pos_mem [MAX_BEADS];
    logic [SUM_W-1:0]     sum_mem [MAX_BEADS];
    logic [COUNT_W-1:0]   cnt_mem [MAX_BEADS];

    state_t state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] clr_reg;
    logic [3*POS_W-1:0] pos_i_q, pos_j_q;
    logic [SUM_W-1:0]   sum_q;
    logic [COUNT_W-1:0] cnt_q;

    logic accept_in;
    assign accept_in = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    logic in_window;
    assign in_window = (in_item.frame_time >= wstart_reg) &&
                       (in_item.frame_time <= wend_reg);

    logic [IDX_W-1:0] sep;
    assign sep = (state_reg == ST_FIN_RD) ? i_reg : IDX_W'(i_reg - j_reg);

    // write new values, registered reads
    logic             acc_we;
    logic [SUM_W-1:0] sum_wr;
    logic [COUNT_W-1:0] cnt_wr;
    logic             clearing;
    assign clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge clk)
    begin
        if (accept_in && in_item.cmd == CMD_LOAD)
            pos_mem[in_item.bead_index] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
        pos_i_q <= pos_mem[i_reg];
        pos_j_q <= pos_mem[j_reg];
        if (clearing)
        begin
            sum_mem[clr_reg] <= '0;
            cnt_mem[clr_reg] <= '0;
        end
        else if (acc_we)
        begin
            sum_mem[sep] <= sum_wr;
            cnt_mem[sep] <= cnt_wr;
        end
        sum_q <= sum_mem[sep];
        cnt_q <= cnt_mem[sep];
    end

    // squared distances
    logic signed [POS_W:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]       dist_reg;
    logic [2*POS_W+1:0]    sqx, sqy, sqz;
    assign sqx = 50'($signed(dx_reg) * $signed(dx_reg));
    assign sqy = 50'($signed(dy_reg) * $signed(dy_reg));
    assign sqz = 50'($signed(dz_reg) * $signed(dz_reg));

    logic [SUM_W:0] sum_add;
    assign sum_add = {1'b0, sum_q} + {15'd0, dist_reg};
    assign sum_wr  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_wr  = (&cnt_q) ? cnt_q : cnt_q + COUNT_W'(1);
    assign acc_we  = (state_reg == ST_PAIR_WR);

    // bit-serial divider
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W:0]   rem_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [6:0]         bit_reg;
    logic [COUNT_W:0]   rem_sh;
    assign rem_sh = {rem_reg[COUNT_W-1:0], quo_reg[SUM_W-1]};
    logic div_done;
    assign div_done = (bit_reg == 7'd0);

    logic out_take;
    assign out_take = out_valid && out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        case (state_reg)
            ST_CLEAR:
                if (&clr_reg)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept_in)
                begin
                    i_next = '0;
                    j_next = '0;
                    if (in_item.cmd == CMD_FINISH)
                        state_next = ST_FIN_RD;
                    else if (in_item.frame_end && in_window)
                        state_next = ST_PAIR_RD;
                end
            ST_PAIR_RD:  state_next = ST_PAIR_SQ;
            ST_PAIR_SQ:  state_next = ST_PAIR_SUM;
            ST_PAIR_SUM: state_next = ST_PAIR_WR;
            ST_PAIR_WR:
            begin
                state_next = ST_PAIR_RD;
                if (j_reg == i_reg)
                begin
                    j_next = '0;
                    i_next = IDX_W'(i_reg + 1'b1);
                    if ({1'b0, i_reg} == CNT_W'(n_beads - 1'b1))
                        state_next = ST_IDLE;
                end
                else
                    j_next = IDX_W'(j_reg + 1'b1);
            end
            ST_FIN_RD:  state_next = ST_FIN_DIV;
            ST_FIN_DIV:
                if (div_done)
                    state_next = ST_FIN_OUT;
            ST_FIN_OUT:
                if (out_take)
                begin
                    if ({1'b0, i_reg} == CNT_W'(n_beads - CNT_W'(2)))
                        state_next = ST_IDLE;
                    else
                    begin
                        i_next = IDX_W'(i_reg + 1'b1);
                        state_next = ST_FIN_RD;
                    end
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (clearing)
                clr_reg <= IDX_W'(clr_reg + 1'b1);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dx_reg <= $signed(pos_i_q[3*POS_W-1:2*POS_W]) - $signed(pos_j_q[3*POS_W-1:2*POS_W]);
        dy_reg <= $signed(pos_i_q[2*POS_W-1:POS_W]) - $signed(pos_j_q[2*POS_W-1:POS_W]);
        dz_reg <= $signed(pos_i_q[POS_W-1:0]) - $signed(pos_j_q[POS_W-1:0]);
        dist_reg <= sqx + sqy + sqz;
        if (state_reg == ST_FIN_DIV && bit_reg == 7'd64)
        begin
            quo_reg <= sum_q;
            rem_reg <= '0;
            div_reg <= cnt_q;
            bit_reg <= 7'd63;
        end
        else if (state_reg == ST_FIN_DIV)
        begin
            if (rem_sh >= {1'b0, div_reg})
                rem_reg <= rem_sh - {1'b0, div_reg};
            else
                rem_reg <= rem_sh;
            quo_reg <= {quo_reg[SUM_W-2:0], rem_sh >= {1'b0, div_reg}};
            bit_reg <= bit_reg - 7'd1;
        end
        else
            bit_reg <= 7'd64;
    end

    // outputs
    logic no_data;
    assign no_data = (div_reg == '0);
    always_comb
    begin
        out_valid = (state_reg == ST_FIN_OUT);
        out_item.separation = i_reg;
        out_item.mean_sq_distance = no_data ? '0 : quo_reg;
        out_item.no_data = no_data;
        out_item.last = ({1'b0, i_reg} == CNT_W'(n_beads - CNT_W'(2)));
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_j_le_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAIR_WR) |-> (j_reg <= i_reg))
        else $error("pair index order broken");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(i_reg)))
        else $error("result dropped under stall");
`endif

endmodule

>>> sim/tb_pair_distance_by_separation.sv
// Testbench for pair_distance_by_separation: bead loads, frame accumulation, mean per separation.
`timescale 1ns / 1ps

module tb_pair_distance_by_separation;
    import pds_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    // longest frame accumulation: 64*65/2 pairs, plus margin
    localparam int SETTLE_CYCLES = 8500;
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pair_distance_by_separation DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: register copies, bead positions, per-separation totals
    logic [6:0] beads_reg = 7'd64;
    logic [30:0] wstart_reg = '0;
    logic [30:0] wend_reg = TIME_MAX;
    logic signed [23:0] bead_x [MAX_BEADS];
    logic signed [23:0] bead_y [MAX_BEADS];
    logic signed [23:0] bead_z [MAX_BEADS];
    logic [63:0] sep_sum [MAX_BEADS];
    logic [39:0] sep_count [MAX_BEADS];

    in_item_t pending_items [$];
    out_item_t expected_means [$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_finishes = 0;
    int n_frames_in = 0;
    int cycles = 0;
    bit no_idle = 1'b0;
    bit long_hold_req = 1'b0;

    initial
    begin
        for (int k = 0; k < MAX_BEADS; k++)
        begin
            sep_sum[k] = '0;
            sep_count[k] = '0;
            bead_x[k] = '0;
            bead_y[k] = '0;
            bead_z[k] = '0;
        end
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int active_beads();
        if (beads_reg < 7'd2)
            return 2;
        if (beads_reg > 7'(MAX_BEADS))
            return MAX_BEADS;
        return int'(beads_reg);
    endfunction

    function automatic logic [63:0] coord_sq(logic signed [23:0] a, logic signed [23:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d * d);
    endfunction

    // Apply one transferred item to the predictor and queue the means it yields
    task automatic predict_item(in_item_t it);
        int n;
        logic [63:0] d;
        out_item_t r;
        n = active_beads();
        if (it.cmd == CMD_LOAD)
        begin
            bead_x[it.bead_index] = it.pos_x;
            bead_y[it.bead_index] = it.pos_y;
            bead_z[it.bead_index] = it.pos_z;
            if (it.frame_end && it.frame_time >= wstart_reg && it.frame_time <= wend_reg)
            begin
                n_frames_in++;
                for (int i = 0; i < n; i++)
                    for (int j = 0; j <= i; j++)
                    begin
                        d = coord_sq(bead_x[i], bead_x[j]) + coord_sq(bead_y[i], bead_y[j])
                            + coord_sq(bead_z[i], bead_z[j]);
                        if (sep_sum[i-j] > ~64'd0 - d)
                            sep_sum[i-j] = ~64'd0;
                        else
                            sep_sum[i-j] = sep_sum[i-j] + d;
                        if (sep_count[i-j] != ~40'd0)
                            sep_count[i-j] = sep_count[i-j] + 40'd1;
                    end
            end
        end
        else
        begin
            for (int k = 0; k + 1 < n; k++)
            begin
                r.separation = 6'(k);
                r.no_data = (sep_count[k] == '0);
                r.mean_sq_distance = r.no_data ? 64'd0 : sep_sum[k] / 64'(sep_count[k]);
                r.last = (k + 2 == n);
                expected_means.push_back(r);
            end
        end
    endtask

    // Sender: offer queued items with random gaps
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_item(in_item);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 7);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, check each transfer
    int recv_hold = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_means.size() == 0)
                begin
                    $error("unexpected result: separation %0d", out_item.separation);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_means.pop_front();
                    if (out_item.separation !== e.separation)
                    begin
                        $error("separation: expected %0d, got %0d",
                               e.separation, out_item.separation);
                        errors++;
                    end
                    if (out_item.mean_sq_distance !== e.mean_sq_distance)
                    begin
                        $error("mean_sq_distance: expected %0h, got %0h",
                               e.mean_sq_distance, out_item.mean_sq_distance);
                        errors++;
                    end
                    if (out_item.no_data !== e.no_data)
                    begin
                        $error("no_data: expected %0b, got %0b", e.no_data, out_item.no_data);
                        errors++;
                    end
                    if (out_item.last !== e.last)
                    begin
                        $error("last: expected %0b, got %0b", e.last, out_item.last);
                        errors++;
                    end
                end
                recv_hold = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_hold = 3000;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_BEADS)
            beads_reg = value[6:0];
        else if (addr == ADDR_WSTART)
            wstart_reg = value[30:0];
        else if (addr == ADDR_WEND)
            wend_reg = value[30:0];
    endtask

    task automatic configure(logic [6:0] beads, logic [30:0] ws, logic [30:0] we);
        reg_write(ADDR_BEADS, 32'(beads));
        reg_write(ADDR_WSTART, 32'(ws));
        reg_write(ADDR_WEND, 32'(we));
    endtask

    // Hold until every item is transferred, every mean checked and the block settled
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_means.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_load(int idx, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic [30:0] t, bit fe);
        in_item_t it;
        it.cmd = CMD_LOAD;
        it.bead_index = 6'(idx);
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.frame_time = t;
        it.frame_end = fe;
        pending_items.push_back(it);
        n_items++;
    endtask

    task automatic push_finish();
        in_item_t it;
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
        it.cmd = CMD_FINISH;
        pending_items.push_back(it);
        n_items++;
        n_finishes++;
    endtask

    // Random coordinate: sometimes clustered, sometimes full range
    function automatic logic [23:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return 24'($urandom);
        return 24'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    // Well-formed frame over beads 0..n-1, frame_end on the last load
    task automatic push_frame(int n, logic [30:0] t);
        for (int i = 0; i < n; i++)
            push_load(i, rand_coord(), rand_coord(), rand_coord(), t, i == n - 1);
    endtask

    initial
    begin
        int n;
        logic [30:0] ws;
        logic [30:0] we;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: four beads, two at the coordinate extremes, window wide open
        configure(7'd4, 31'd0, TIME_MAX);
        push_load(0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 31'd5, 1'b0);
        push_load(1, 24'h800000, 24'h7FFFFF, 24'h800000, 31'd5, 1'b0);
        push_load(2, 24'h000000, 24'h000000, 24'h000000, 31'd5, 1'b0);
        push_load(3, 24'hFFFFFF, 24'h000001, 24'h7FFFFF, 31'd0, 1'b1);
        push_finish();
        // out-of-range index closes a frame at the latest time
        push_load(63, 24'h123456, 24'hABCDEF, 24'h800000, TIME_MAX, 1'b1);
        // identical beads: zero distances
        for (int i = 0; i < 4; i++)
            push_load(i, 24'h001000, 24'h001000, 24'h001000, 31'd9, i == 3);
        push_finish();
        drain();

        // Bead count below range acts as two; window edges
        configure(7'd0, 31'd100, 31'd200);
        push_load(1, 24'h000100, 24'h000000, 24'h000000, 31'd99, 1'b1);
        push_load(0, 24'h000000, 24'h000200, 24'h000000, 31'd100, 1'b1);
        push_load(1, 24'h000000, 24'h000000, 24'h000300, 31'd200, 1'b1);
        push_load(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 31'd201, 1'b1);
        push_finish();
        drain();

        // Bead count above range acts as 64; full frame under a long output stall
        configure(7'd127, 31'd0, TIME_MAX);
        long_hold_req = 1'b1;
        push_finish();
        push_frame(MAX_BEADS, 31'($urandom));
        push_finish();
        drain();

        // Empty window: nothing accumulates
        configure(7'd64, 31'd500, 31'd10);
        push_frame(3, 31'd300);
        push_finish();
        drain();

        // Random phases of mostly small frames
        while (n_items < 220)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(2, 9);
            ws = 31'($urandom_range(0, 1000));
            we = ($urandom_range(0, 5) == 0) ? ws - 31'd1 : ws + 31'($urandom_range(0, 1000));
            configure(7'(n), ws, we);
            repeat ($urandom_range(2, 5))
            begin
                case ($urandom_range(0, 9))
                    0: push_load($urandom_range(0, 63), 24'($urandom), 24'($urandom),
                                 24'($urandom), 31'($urandom), 1'b0);
                    1:
                    begin
                        // broken frame: some beads keep older positions
                        push_load($urandom_range(0, n - 1), rand_coord(), rand_coord(),
                                  rand_coord(), 31'($urandom_range(0, 2100)), 1'b0);
                        push_load($urandom_range(0, 63), rand_coord(), rand_coord(),
                                  rand_coord(), 31'($urandom_range(0, 2100)), 1'b1);
                    end
                    default: push_frame(n, 31'($urandom_range(0, 2100)));
                endcase
            end
            push_finish();
            drain();
        end
        no_idle = 1'b0;

        $display("Covered %0d items, %0d finishes, %0d frames accumulated, %0d means checked.",
                 n_items, n_finishes, n_frames_in, n_results);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
